// File: src/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types, constants and helpers of the LED breathing PWM unit.
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int NUM_LEDS = 3;
  localparam int STEP_MS  = 10;

  localparam int LED_W    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int PWM_TOP  = STEP_MS * 10;
  localparam int CNT_W    = $clog2(PWM_TOP + 1);
  localparam int PCT      = 100;
  localparam int PCT_W    = 7;
  localparam int CYC_MIN  = 100;
  localparam int PER_MAX  = 65535 / STEP_MS;
  localparam int PER_W    = $clog2(PER_MAX + 1);
  localparam int PROD_MAX = (PER_MAX * PCT > 65535) ? PER_MAX * PCT : 65535;
  localparam int DVD_W    = $clog2(PROD_MAX + 1);
  localparam int DCNT_W   = $clog2(DVD_W);
  localparam int MUL_A_W  = 16;
  localparam int MUL_P_W  = MUL_A_W + PCT_W;
  localparam int REP_W    = 16;
  localparam int PIN_W    = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET_PER,
    ST_SET_ON,
    ST_SET_RISE,
    ST_SET_FALL,
    ST_SET_WR,
    ST_TICK,
    ST_ADV,
    ST_RAMP,
    ST_DUTY,
    ST_DUTY_WR,
    ST_DIV,
    ST_DONE
  } state_t;

  function automatic logic [PCT_W-1:0] clamp100(input logic [7:0] v);
    return (v > 8'(PCT)) ? PCT_W'(PCT) : v[PCT_W-1:0];
  endfunction

endpackage

// File: src/led_breathing_pattern_pwm_unit.sv
// ----------------------------------------------------------------------------
// led_breathing_pattern_pwm_unit
// Software PWM for several LEDs with blink and breathing patterns.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): kind 1 loads the pattern of one LED
// (ignored when led_index is out of range, no result); kind 0 is one PWM
// tick and gives exactly one result beat on the output channel
// (out_valid/out_ready) with led_pins and pattern_stepped.
// All divisions run on one shared restoring divider, one quotient bit per
// cycle over a DVD_W (20) bit dividend, loaded by the state that starts it.
// A set beat takes 4 divisions, and no new beat is taken until they finish.
// A tick beat without a pattern step goes from ST_TICK to ST_DONE, which
// raises out_valid once the output register is free; a stepping tick
// (one in every PWM_TOP ticks) walks the LEDs, up to 2 divisions each, and
// then raises out_valid from ST_DONE in the same way.
// in_ready is high only while idle.
// A result waiting on a stalled receiver sits in the output register; the
// unit still takes the next beat and holds its own result until that
// register frees up.
// Reset clears the PWM counter, marks all LEDs unset (duty cleared, so later
// results show their pins low) and drops any pending result.
// ----------------------------------------------------------------------------
module led_breathing_pattern_pwm_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [1:0]                    led_index,
  input  logic [15:0]                   cycle_time_ms,
  input  logic [7:0]                    duty_percent,
  input  logic [7:0]                    on_brightness,
  input  logic [7:0]                    off_brightness,
  input  logic [7:0]                    rise_percent,
  input  logic [7:0]                    fall_percent,
  input  logic signed [15:0]            repeat_times,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lbp_pkg::PIN_W-1:0]     led_pins,
  output logic                          pattern_stepped
);

  localparam int PER_W  = lbp_pkg::PER_W;
  localparam int PCT_W  = lbp_pkg::PCT_W;
  localparam int DVD_W  = lbp_pkg::DVD_W;
  localparam int LED_W  = lbp_pkg::LED_W;
  localparam int NLED   = lbp_pkg::NUM_LEDS;

  lbp_pkg::state_t state, state_next, ret;

  // per-LED pattern state
  logic [PER_W-1:0]                per_steps [NLED];
  logic [PER_W-1:0]                on_steps  [NLED];
  logic [PER_W-1:0]                rise_steps[NLED];
  logic [PER_W-1:0]                fall_steps[NLED];
  logic [PCT_W-1:0]                bright_hi [NLED];
  logic [PCT_W-1:0]                bright_lo [NLED];
  logic [PER_W-1:0]                phase     [NLED];
  logic [PER_W-1:0]                rise_cnt  [NLED];
  logic [PER_W-1:0]                fall_cnt  [NLED];
  logic signed [lbp_pkg::REP_W-1:0] reps     [NLED];
  logic [PCT_W-1:0]                duty      [NLED];

  logic [lbp_pkg::CNT_W-1:0]       pwm_cnt;
  logic                            stepped;
  logic [LED_W-1:0]                led;

  // latched set beat
  logic [LED_W-1:0]                idx_r;
  logic [15:0]                     cyc_r;
  logic [PCT_W-1:0]                dty_r, hi_r, lo_r, rsp_r, fsp_r;
  logic signed [lbp_pkg::REP_W-1:0] rep_r;
  logic [PER_W-1:0]                t_per, t_on, t_rise;
  logic [PCT_W-1:0]                ramp;

  // shared divider
  logic [DVD_W-1:0]                dvd;
  logic [PER_W-1:0]                rem;
  logic [PER_W-1:0]                dvs;
  logic [lbp_pkg::DCNT_W-1:0]      dcnt;
  logic [PER_W:0]                  trial;
  logic                            trial_ge;
  logic [PER_W-1:0]                quo;

  // shared multiplier feeding the divider
  logic                            ld_div;
  logic [lbp_pkg::MUL_A_W-1:0]     mul_a;
  logic [PCT_W-1:0]                mul_b;
  logic [lbp_pkg::MUL_P_W-1:0]     mul_p;
  logic [PER_W-1:0]                dvs_sel;
  lbp_pkg::state_t                 ret_sel;

  // pattern step of the current LED
  logic [PER_W-1:0]                c_per, c_on, c_rs, c_fs, c_ph, c_rc, c_fc;
  logic signed [lbp_pkg::REP_W-1:0] c_rep;
  logic                            rep_pos;
  logic [PER_W-1:0]                ph0;
  logic [PER_W:0]                  ph1;
  logic [PER_W-1:0]                ph_n, rc_n, fc_n, ramp_num;
  logic                            in_on, ramp_direct, rep_dec;
  logic [PCT_W-1:0]                ramp_fix;
  logic                            span_neg;
  logic [PCT_W-1:0]                span_mag;
  logic                            last_led, idx_ok, out_free;
  logic [lbp_pkg::PIN_W-1:0]       pins;

  assign in_ready = (state == lbp_pkg::ST_IDLE);
  assign idx_ok   = 32'(led_index) < NLED;
  assign out_free = !out_valid || out_ready;
  assign last_led = (led == LED_W'(NLED - 1));
  assign quo      = dvd[PER_W-1:0];

  assign trial    = {rem, dvd[DVD_W-1]};
  assign trial_ge = trial >= {1'b0, dvs};

  assign c_per = per_steps[led];
  assign c_on  = on_steps[led];
  assign c_rs  = rise_steps[led];
  assign c_fs  = fall_steps[led];
  assign c_ph  = phase[led];
  assign c_rc  = rise_cnt[led];
  assign c_fc  = fall_cnt[led];
  assign c_rep = reps[led];

  always_comb begin
    rep_pos = !c_rep[lbp_pkg::REP_W-1] && (c_rep != '0);
    ph0     = (c_rep == '0) ? c_on : c_ph;
    ph1     = {1'b0, ph0} + (PER_W+1)'(1);
    ph_n    = (ph1 >= {1'b0, c_per}) ? PER_W'(ph1 - {1'b0, c_per}) : ph1[PER_W-1:0];
    rep_dec = rep_pos && (ph_n == c_per - PER_W'(1));
    in_on   = ph_n < c_on;
    rc_n    = '0;
    fc_n    = '0;
    if (in_on) begin
      rc_n        = (c_rs != '0 && c_rc < c_rs) ? c_rc + PER_W'(1) : c_rc;
      ramp_direct = (c_rs == '0);
      ramp_fix    = PCT_W'(lbp_pkg::PCT);
      ramp_num    = rc_n;
    end else begin
      fc_n        = (c_fs != '0 && c_fc < c_fs) ? c_fc + PER_W'(1) : c_fc;
      ramp_direct = (c_fs == '0);
      ramp_fix    = '0;
      ramp_num    = c_fs - fc_n;
    end
    span_neg = bright_lo[led] > bright_hi[led];
    span_mag = span_neg ? bright_lo[led] - bright_hi[led] : bright_hi[led] - bright_lo[led];
  end

  always_comb begin
    state_next = state;
    case (state)
      lbp_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (kind) begin
            state_next = idx_ok ? lbp_pkg::ST_SET_PER : lbp_pkg::ST_IDLE;
          end else begin
            state_next = lbp_pkg::ST_TICK;
          end
        end
      end
      lbp_pkg::ST_SET_PER, lbp_pkg::ST_SET_ON, lbp_pkg::ST_SET_RISE,
      lbp_pkg::ST_SET_FALL, lbp_pkg::ST_DUTY: begin
        state_next = lbp_pkg::ST_DIV;
      end
      lbp_pkg::ST_DIV: begin
        if (dcnt == lbp_pkg::DCNT_W'(DVD_W - 1)) state_next = ret;
      end
      lbp_pkg::ST_SET_WR: begin
        state_next = lbp_pkg::ST_IDLE;
      end
      lbp_pkg::ST_TICK: begin
        state_next = (32'(pwm_cnt) >= lbp_pkg::PWM_TOP) ? lbp_pkg::ST_ADV : lbp_pkg::ST_DONE;
      end
      lbp_pkg::ST_ADV: begin
        if (c_per == '0) begin
          state_next = last_led ? lbp_pkg::ST_DONE : lbp_pkg::ST_ADV;
        end else begin
          state_next = ramp_direct ? lbp_pkg::ST_DUTY : lbp_pkg::ST_DIV;
        end
      end
      lbp_pkg::ST_RAMP: begin
        state_next = lbp_pkg::ST_DUTY;
      end
      lbp_pkg::ST_DUTY_WR: begin
        state_next = last_led ? lbp_pkg::ST_DONE : lbp_pkg::ST_ADV;
      end
      lbp_pkg::ST_DONE: begin
        if (out_free) state_next = lbp_pkg::ST_IDLE;
      end
      default: begin
        state_next = lbp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ld_div  = 1'b0;
    mul_a   = '0;
    mul_b   = PCT_W'(1);
    dvs_sel = PER_W'(lbp_pkg::PCT);
    ret_sel = lbp_pkg::ST_IDLE;
    case (state)
      lbp_pkg::ST_SET_PER: begin
        ld_div  = 1'b1;
        mul_a   = cyc_r;
        dvs_sel = PER_W'(lbp_pkg::STEP_MS);
        ret_sel = lbp_pkg::ST_SET_ON;
      end
      lbp_pkg::ST_SET_ON: begin
        ld_div  = 1'b1;
        mul_a   = lbp_pkg::MUL_A_W'(quo);
        mul_b   = dty_r;
        ret_sel = lbp_pkg::ST_SET_RISE;
      end
      lbp_pkg::ST_SET_RISE: begin
        ld_div  = 1'b1;
        mul_a   = lbp_pkg::MUL_A_W'(quo);
        mul_b   = rsp_r;
        ret_sel = lbp_pkg::ST_SET_FALL;
      end
      lbp_pkg::ST_SET_FALL: begin
        ld_div  = 1'b1;
        mul_a   = lbp_pkg::MUL_A_W'(t_per - t_on);
        mul_b   = fsp_r;
        ret_sel = lbp_pkg::ST_SET_WR;
      end
      lbp_pkg::ST_ADV: begin
        ld_div  = (c_per != '0) && !ramp_direct;
        mul_a   = lbp_pkg::MUL_A_W'(ramp_num);
        mul_b   = PCT_W'(lbp_pkg::PCT);
        dvs_sel = in_on ? c_rs : c_fs;
        ret_sel = lbp_pkg::ST_RAMP;
      end
      lbp_pkg::ST_DUTY: begin
        ld_div  = 1'b1;
        mul_a   = lbp_pkg::MUL_A_W'(ramp);
        mul_b   = span_mag;
        ret_sel = lbp_pkg::ST_DUTY_WR;
      end
      default: begin
        ld_div = 1'b0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    pins = '0;
    for (int i = 0; i < lbp_pkg::PIN_W; i++) begin
      if (i < NLED) pins[i] = 32'(pwm_cnt) < 32'(duty[i]);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lbp_pkg::ST_IDLE;
      out_valid <= 1'b0;
      pwm_cnt   <= '0;
      for (int i = 0; i < NLED; i++) begin
        per_steps[i] <= '0;
        duty[i]      <= '0;
      end
    end else begin
      state <= state_next;
      if (state == lbp_pkg::ST_TICK && 32'(pwm_cnt) >= lbp_pkg::PWM_TOP) pwm_cnt <= '0;
      if (state == lbp_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
        pwm_cnt   <= pwm_cnt + lbp_pkg::CNT_W'(1);
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == lbp_pkg::ST_SET_WR) per_steps[idx_r] <= t_per;
      if (state == lbp_pkg::ST_DUTY_WR) begin
        duty[led] <= span_neg ? bright_lo[led] - quo[PCT_W-1:0]
                              : bright_lo[led] + quo[PCT_W-1:0];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == lbp_pkg::ST_IDLE && in_valid) begin
      idx_r <= LED_W'(led_index);
      cyc_r <= (cycle_time_ms < 16'(lbp_pkg::CYC_MIN)) ? 16'(lbp_pkg::CYC_MIN) : cycle_time_ms;
      dty_r <= lbp_pkg::clamp100(duty_percent);
      hi_r  <= lbp_pkg::clamp100(on_brightness);
      lo_r  <= lbp_pkg::clamp100(off_brightness);
      rsp_r <= lbp_pkg::clamp100(rise_percent);
      fsp_r <= lbp_pkg::clamp100(fall_percent);
      rep_r <= repeat_times;
    end
    if (ld_div) begin
      dvd  <= mul_p[DVD_W-1:0];
      rem  <= '0;
      dcnt <= '0;
      dvs  <= dvs_sel;
      ret  <= ret_sel;
    end else if (state == lbp_pkg::ST_DIV) begin
      rem  <= trial_ge ? PER_W'(trial - {1'b0, dvs}) : trial[PER_W-1:0];
      dvd  <= {dvd[DVD_W-2:0], trial_ge};
      dcnt <= dcnt + lbp_pkg::DCNT_W'(1);
    end
    case (state)
      lbp_pkg::ST_SET_ON:   t_per  <= quo;
      lbp_pkg::ST_SET_RISE: t_on   <= quo;
      lbp_pkg::ST_SET_FALL: t_rise <= quo;
      lbp_pkg::ST_SET_WR: begin
        on_steps[idx_r]   <= t_on;
        rise_steps[idx_r] <= t_rise;
        fall_steps[idx_r] <= quo;
        bright_hi[idx_r]  <= hi_r;
        bright_lo[idx_r]  <= lo_r;
        phase[idx_r]      <= '0;
        rise_cnt[idx_r]   <= '0;
        fall_cnt[idx_r]   <= '0;
        reps[idx_r]       <= rep_r;
      end
      lbp_pkg::ST_TICK: begin
        stepped <= 32'(pwm_cnt) >= lbp_pkg::PWM_TOP;
        led     <= '0;
      end
      lbp_pkg::ST_ADV: begin
        if (c_per == '0) begin
          if (!last_led) led <= led + LED_W'(1);
        end else begin
          phase[led]    <= ph_n;
          rise_cnt[led] <= rc_n;
          fall_cnt[led] <= fc_n;
          if (rep_dec) reps[led] <= c_rep - lbp_pkg::REP_W'(1);
          if (ramp_direct) ramp <= ramp_fix;
        end
      end
      lbp_pkg::ST_RAMP: ramp <= quo[PCT_W-1:0];
      lbp_pkg::ST_DUTY_WR: begin
        if (!last_led) led <= led + LED_W'(1);
      end
      lbp_pkg::ST_DONE: begin
        if (out_free) begin
          led_pins        <= pins;
          pattern_stepped <= stepped;
        end
      end
      default: begin
        ramp <= ramp;
      end
    endcase
  end

endmodule

// File: src/lbp_checker.sv
// ----------------------------------------------------------------------------
// lbp_checker
// Port-level checks of the LED breathing PWM unit, bound to the top level.
// ----------------------------------------------------------------------------
module lbp_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      kind,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [lbp_pkg::PIN_W-1:0] led_pins,
  input logic                      pattern_stepped
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(led_pins) && $stable(pattern_stepped))
    else $error("result beat changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat pending after reset");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !kind |=> !in_ready)
    else $error("tick beat did not occupy the unit");

  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result beat appeared right after an input beat");

endmodule

bind led_breathing_pattern_pwm_unit lbp_checker u_lbp_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .kind            (kind),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .led_pins        (led_pins),
  .pattern_stepped (pattern_stepped)
);
